FILE: rtl/apc_pkg.sv
// shared types and constants of the pileup counter
`default_nettype none

package apc_pkg;

   // request opcodes
   localparam logic [2:0] OP_LOAD   = 3'd0;
   localparam logic [2:0] OP_START  = 3'd1;
   localparam logic [2:0] OP_M      = 3'd2;
   localparam logic [2:0] OP_EQUAL  = 3'd3;
   localparam logic [2:0] OP_X      = 3'd4;
   localparam logic [2:0] OP_INSERT = 3'd5;
   localparam logic [2:0] OP_DELETE = 3'd6;
   localparam logic [2:0] OP_READ   = 3'd7;

   localparam int FIELD_BITS  = 16;
   localparam int CURSOR_BITS = 17;
   localparam logic [CURSOR_BITS-1:0] CURSOR_MAX = '1;
   localparam int NUM_SLOTS   = 8;
   localparam int QUEUE_DEPTH = 4;

   // counter slots within one table row
   localparam logic [2:0] SLOT_MATCH  = 3'd0;
   localparam logic [2:0] SLOT_MIS_A  = 3'd1;
   localparam logic [2:0] SLOT_DEL    = 3'd5;
   localparam logic [2:0] SLOT_INS    = 3'd6;
   localparam logic [2:0] SLOT_INSLEN = 3'd7;

   typedef enum logic [2:0] {
      CMD_LOAD,
      CMD_READ,
      CMD_MCMP,
      CMD_MATCH,
      CMD_MIS,
      CMD_DEL,
      CMD_INS
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [1:0]              code;
      logic                    in_range;
      logic [FIELD_BITS-1:0]   ins_length;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/apc_queue.sv
// small command queue between the front and back parts
`default_nettype none

module apc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/apc_front.sv
// front part: accepts requests, tracks the cursor and classifies events
`default_nettype none

module apc_front #(
   parameter int REF_DEPTH = 65536
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [2:0]                          req_op,
   input  wire logic [15:0]                         req_position,
   input  wire logic [3:0]                          req_base,
   input  wire logic [15:0]                         req_ins_length,
   input  wire logic                                req_secondary,
   input  wire logic                                clear_busy,
   input  wire logic                                queue_full,
   output logic                                     push,
   output apc_pkg::cmd_type                         push_cmd,
   output logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] push_addr
);

   localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;

   logic [apc_pkg::CURSOR_BITS-1:0] cursor_ff, cursor_in;
   logic                            skip_ff, skip_in;
   logic                            accept;
   logic                            advance;
   logic                            base_ok;
   logic [1:0]                      base_code;
   logic                            cur_in_range;
   logic                            pos_in_range;

   assign req_ready    = !clear_busy && !queue_full;
   assign accept       = req_valid && req_ready;
   assign base_ok      = $onehot(req_base);
   assign base_code    = {req_base[3] | req_base[2], req_base[3] | req_base[1]};
   assign cur_in_range = (32'(cursor_ff) < 32'(REF_DEPTH));
   assign pos_in_range = (32'(req_position) < 32'(REF_DEPTH));

   always_comb begin
      cursor_in           = cursor_ff;
      skip_in             = skip_ff;
      advance             = 1'b0;
      push                = 1'b0;
      push_cmd.kind       = apc_pkg::CMD_READ;
      push_cmd.code       = base_code;
      push_cmd.in_range   = pos_in_range;
      push_cmd.ins_length = req_ins_length;
      push_addr           = AW'(req_position);
      if (accept) begin
         unique case (req_op)
            apc_pkg::OP_LOAD: begin
               push          = pos_in_range;
               push_cmd.kind = apc_pkg::CMD_LOAD;
               push_cmd.code = req_base[1:0];
            end
            apc_pkg::OP_START: begin
               cursor_in = apc_pkg::CURSOR_BITS'(req_position);
               skip_in   = req_secondary;
            end
            apc_pkg::OP_READ: begin
               push          = 1'b1;
               push_cmd.kind = apc_pkg::CMD_READ;
            end
            apc_pkg::OP_M: begin
               advance       = !skip_ff;
               push          = !skip_ff && base_ok && cur_in_range;
               push_cmd.kind = apc_pkg::CMD_MCMP;
               push_addr     = AW'(cursor_ff);
            end
            apc_pkg::OP_EQUAL: begin
               advance       = !skip_ff;
               push          = !skip_ff && cur_in_range;
               push_cmd.kind = apc_pkg::CMD_MATCH;
               push_addr     = AW'(cursor_ff);
            end
            apc_pkg::OP_X: begin
               advance       = !skip_ff;
               push          = !skip_ff && base_ok && cur_in_range;
               push_cmd.kind = apc_pkg::CMD_MIS;
               push_addr     = AW'(cursor_ff);
            end
            apc_pkg::OP_INSERT: begin
               push          = !skip_ff && cur_in_range;
               push_cmd.kind = apc_pkg::CMD_INS;
               push_addr     = AW'(cursor_ff);
            end
            apc_pkg::OP_DELETE: begin
               advance       = !skip_ff;
               push          = !skip_ff && cur_in_range;
               push_cmd.kind = apc_pkg::CMD_DEL;
               push_addr     = AW'(cursor_ff);
            end
         endcase
      end
      // cursor sticks at its top value
      if (advance && (cursor_ff != apc_pkg::CURSOR_MAX)) begin
         cursor_in = cursor_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         skip_ff   <= 1'b1;
      end else begin
         cursor_ff <= cursor_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/apc_back.sv
// back part: counter table read-modify-write, reference store and readout
`default_nettype none

module apc_back #(
   parameter int REF_DEPTH  = 65536,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     queue_valid,
   input  wire apc_pkg::cmd_type         queue_cmd,
   input  wire logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] queue_addr,
   output logic                          queue_pop,
   output logic                          clear_busy,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [15:0]                   rsp_match_count,
   output logic [15:0]                   rsp_mismatch_a,
   output logic [15:0]                   rsp_mismatch_c,
   output logic [15:0]                   rsp_mismatch_g,
   output logic [15:0]                   rsp_mismatch_t,
   output logic [15:0]                   rsp_deletion_count,
   output logic [15:0]                   rsp_insertion_count,
   output logic [15:0]                   rsp_inserted_bases
);

   localparam int AW       = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
   localparam int ROW_BITS = apc_pkg::NUM_SLOTS * COUNT_BITS;
   localparam int SUM_BITS =
      ((COUNT_BITS > apc_pkg::FIELD_BITS) ? COUNT_BITS : apc_pkg::FIELD_BITS) + 1;
   localparam logic [COUNT_BITS-1:0]           LIMIT     = '1;
   localparam logic [apc_pkg::FIELD_BITS-1:0]  FIELD_MAX = '1;
   localparam logic [AW-1:0]                   LAST_ADDR = AW'(REF_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } back_state_type;

   function automatic logic [COUNT_BITS-1:0] sat_add(
      input logic [COUNT_BITS-1:0]          cnt,
      input logic [apc_pkg::FIELD_BITS-1:0] inc
   );
      logic [SUM_BITS-1:0]   sum;
      logic [COUNT_BITS-1:0] res;
      sum = SUM_BITS'(cnt) + SUM_BITS'(inc);
      res = (sum > SUM_BITS'(LIMIT)) ? LIMIT : COUNT_BITS'(sum);
      return res;
   endfunction

   function automatic logic [apc_pkg::FIELD_BITS-1:0] to_field(
      input logic [COUNT_BITS-1:0] cnt
   );
      logic [31:0] wide;
      wide = 32'(cnt);
      return (wide > 32'(FIELD_MAX)) ? FIELD_MAX : wide[apc_pkg::FIELD_BITS-1:0];
   endfunction

   logic [ROW_BITS-1:0] count_mem [REF_DEPTH];
   logic [1:0]          ref_mem   [REF_DEPTH];

   back_state_type       state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   apc_pkg::cmd_type     cmd_ff;
   logic [AW-1:0]        addr_ff;
   logic [ROW_BITS-1:0]  row_ff;
   logic [1:0]           ref_rd_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [apc_pkg::FIELD_BITS-1:0] rsp_ff   [apc_pkg::NUM_SLOTS];
   logic [apc_pkg::FIELD_BITS-1:0] rsp_data [apc_pkg::NUM_SLOTS];
   logic [apc_pkg::FIELD_BITS-1:0] inc      [apc_pkg::NUM_SLOTS];
   logic [ROW_BITS-1:0]  new_row;
   logic                 rd_en;
   logic                 ref_we;
   logic                 cnt_we;
   logic [AW-1:0]        cnt_waddr;
   logic [ROW_BITS-1:0]  cnt_wdata;
   logic                 rsp_load;

   assign clear_busy = (state_ff == ST_CLEAR);

   // increments for the row being updated
   always_comb begin
      for (int j = 0; j < apc_pkg::NUM_SLOTS; j++) begin
         inc[j] = '0;
      end
      unique case (cmd_ff.kind)
         apc_pkg::CMD_MCMP: begin
            if (ref_rd_ff == cmd_ff.code) begin
               inc[apc_pkg::SLOT_MATCH] = 16'd1;
            end else begin
               inc[apc_pkg::SLOT_MIS_A + 3'(cmd_ff.code)] = 16'd1;
            end
         end
         apc_pkg::CMD_MATCH: inc[apc_pkg::SLOT_MATCH] = 16'd1;
         apc_pkg::CMD_MIS:   inc[apc_pkg::SLOT_MIS_A + 3'(cmd_ff.code)] = 16'd1;
         apc_pkg::CMD_DEL:   inc[apc_pkg::SLOT_DEL] = 16'd1;
         apc_pkg::CMD_INS: begin
            inc[apc_pkg::SLOT_INS]    = 16'd1;
            inc[apc_pkg::SLOT_INSLEN] = cmd_ff.ins_length;
         end
         default: ;
      endcase
   end

   always_comb begin
      for (int j = 0; j < apc_pkg::NUM_SLOTS; j++) begin
         new_row[j*COUNT_BITS +: COUNT_BITS] =
            sat_add(row_ff[j*COUNT_BITS +: COUNT_BITS], inc[j]);
         rsp_data[j] = cmd_ff.in_range ?
            to_field(row_ff[j*COUNT_BITS +: COUNT_BITS]) : '0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      queue_pop   = 1'b0;
      rd_en       = 1'b0;
      ref_we      = 1'b0;
      cnt_we      = 1'b0;
      cnt_waddr   = addr_ff;
      cnt_wdata   = new_row;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_ff;
            cnt_wdata = '0;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (queue_valid) begin
               if (queue_cmd.kind == apc_pkg::CMD_LOAD) begin
                  queue_pop = 1'b1;
                  ref_we    = 1'b1;
               end else if (queue_cmd.kind != apc_pkg::CMD_READ || !rsp_valid_ff) begin
                  queue_pop = 1'b1;
                  rd_en     = 1'b1;
                  state_in  = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (cmd_ff.kind == apc_pkg::CMD_READ) begin
               rsp_load = 1'b1;
            end else begin
               cnt_we = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         cmd_ff  <= queue_cmd;
         addr_ff <= queue_addr;
      end
      if (rsp_load) begin
         for (int j = 0; j < apc_pkg::NUM_SLOTS; j++) begin
            rsp_ff[j] <= rsp_data[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         row_ff <= count_mem[queue_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[queue_addr] <= queue_cmd.code;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         ref_rd_ff <= ref_mem[queue_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_match_count     = rsp_ff[apc_pkg::SLOT_MATCH];
   assign rsp_mismatch_a      = rsp_ff[apc_pkg::SLOT_MIS_A];
   assign rsp_mismatch_c      = rsp_ff[apc_pkg::SLOT_MIS_A + 3'd1];
   assign rsp_mismatch_g      = rsp_ff[apc_pkg::SLOT_MIS_A + 3'd2];
   assign rsp_mismatch_t      = rsp_ff[apc_pkg::SLOT_MIS_A + 3'd3];
   assign rsp_deletion_count  = rsp_ff[apc_pkg::SLOT_DEL];
   assign rsp_insertion_count = rsp_ff[apc_pkg::SLOT_INS];
   assign rsp_inserted_bases  = rsp_ff[apc_pkg::SLOT_INSLEN];

endmodule

`default_nettype wire

FILE: rtl/alignment_pileup_counter.sv
// top level of the pileup counter: front, command queue and back
//
// request channel (req_*): one alignment event, reference load, record start or
// counter readout per request, valid/ready handshake
// response channel (rsp_*): the eight counters of one position, only for a
// readout request, held in an output register until taken
// the front takes one request per cycle once the clearing pass is done and while the
// command queue has room; record starts and skipped events never enter the queue
// the back works one command at a time: a reference load is written straight from
// the queue, while a counter update or readout first reads the count memory into a
// register, then writes the row back or loads the output register
// an accepted readout passes the queue, the row read and the output register before rsp_valid
// after reset the back sweeps the count memory to zero, one row a cycle, over all
// REF_DEPTH rows; req_ready stays low for that whole pass
// a stalled response holds its register; the back keeps draining updates and
// only waits when the next readout finds the output register still full
// once the queue fills, req_ready drops until the back catches up
`default_nettype none

module alignment_pileup_counter #(
   parameter int REF_DEPTH  = 65536,
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [15:0] req_position,
   input  wire logic [3:0]  req_base,
   input  wire logic [15:0] req_ins_length,
   input  wire logic        req_secondary,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_match_count,
   output logic [15:0]      rsp_mismatch_a,
   output logic [15:0]      rsp_mismatch_c,
   output logic [15:0]      rsp_mismatch_g,
   output logic [15:0]      rsp_mismatch_t,
   output logic [15:0]      rsp_deletion_count,
   output logic [15:0]      rsp_insertion_count,
   output logic [15:0]      rsp_inserted_bases
);

   // table address width
   localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
   // queue entry: address on top of the classified command
   localparam int QW = AW + $bits(apc_pkg::cmd_type);

   logic             push;
   apc_pkg::cmd_type push_cmd;
   logic [AW-1:0]    push_addr;
   logic [QW-1:0]    queue_out;
   logic             queue_full;
   logic             queue_empty;
   logic             queue_pop;
   logic             clear_busy;
   apc_pkg::cmd_type queue_cmd;
   logic [AW-1:0]    queue_addr;

   // request side: cursor, skip flag and event classification
   apc_front #(
      .REF_DEPTH (REF_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_base       (req_base),
      .req_ins_length (req_ins_length),
      .req_secondary  (req_secondary),
      .clear_busy     (clear_busy),
      .queue_full     (queue_full),
      .push           (push),
      .push_cmd       (push_cmd),
      .push_addr      (push_addr)
   );

   // decouples request intake from the table pipeline
   apc_queue #(
      .WIDTH (QW),
      .DEPTH (apc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_addr, push_cmd}),
      .pop       (queue_pop),
      .pop_data  (queue_out),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign queue_cmd  = apc_pkg::cmd_type'(queue_out[$bits(apc_pkg::cmd_type)-1:0]);
   assign queue_addr = queue_out[QW-1:$bits(apc_pkg::cmd_type)];

   // table side: clearing pass, counter updates and readout register
   apc_back #(
      .REF_DEPTH  (REF_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_valid         (!queue_empty),
      .queue_cmd           (queue_cmd),
      .queue_addr          (queue_addr),
      .queue_pop           (queue_pop),
      .clear_busy          (clear_busy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_match_count     (rsp_match_count),
      .rsp_mismatch_a      (rsp_mismatch_a),
      .rsp_mismatch_c      (rsp_mismatch_c),
      .rsp_mismatch_g      (rsp_mismatch_g),
      .rsp_mismatch_t      (rsp_mismatch_t),
      .rsp_deletion_count  (rsp_deletion_count),
      .rsp_insertion_count (rsp_insertion_count),
      .rsp_inserted_bases  (rsp_inserted_bases)
   );

endmodule

`default_nettype wire

FILE: rtl/apc_checker.sv
// port-level checks of the pileup counter and their binding
`default_nettype none

module apc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_match_count,
   input wire logic [15:0] rsp_inserted_bases
);

   // reset empties the output register and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("response or request intake active right after reset");

   // clearing pass keeps intake closed
   a_clear_holds: assert property (@(posedge clock)
      reset |=> ##1 !req_ready)
      else $error("request intake opened during clearing pass");

   // stalled response keeps its values
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count)
         && $stable(rsp_inserted_bases))
      else $error("stalled response changed");

   // readouts wait for an empty output register, so responses never follow each other
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("responses delivered in consecutive cycles");

endmodule

bind alignment_pileup_counter apc_checker u_apc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_match_count    (rsp_match_count),
   .rsp_inserted_bases (rsp_inserted_bases)
);

`default_nettype wire
